### sv/i2ra_pkg.sv
// Shared types, constants and helpers for the integer to radix ASCII converter.
// Used by the controller, datapath and core modules; depends on nothing.
package i2ra_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int IN_VALUE_W      = 32;
  localparam int BASE_W          = 5;
  localparam int CHAR_W          = 8;
  localparam int DIGIT_W         = 4;
  localparam int STEP_BITS       = 8;

  localparam logic [BASE_W-1:0] MIN_RADIX     = 5'd2;
  localparam logic [BASE_W-1:0] MAX_RADIX     = 5'd16;
  localparam logic [BASE_W-1:0] DEFAULT_RADIX = 5'd10;

  localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] ALPHA_OFFSET  = 8'd55;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 4'd10;

  typedef struct packed {
    logic signed [IN_VALUE_W-1:0] value;
    logic [BASE_W-1:0]            base;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic last_step;
    logic prime;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic last_idx;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < DECIMAL_DIGITS) begin
      return ASCII_ZERO + ext;
    end else begin
      return ext + ALPHA_OFFSET;
    end
  endfunction

endpackage

### sv/i2ra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used by the datapath as the digit buffer.
module i2ra_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/i2ra_ctrl.sv
// Controller state machine: sequences load, digit division, and character output.
// Depends on i2ra_pkg for the command and status structs.
module i2ra_ctrl #(
  parameter int VALUE_WIDTH = i2ra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  i2ra_pkg::dp_status_t  status,
  output i2ra_pkg::ctl_cmd_t    cmd
);
  import i2ra_pkg::*;

  localparam int STEPS  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_PRIME = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_cnt_r, step_cnt_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          step_cnt_nxt = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step      = 1'b1;
        cmd.last_step = (step_cnt_r == LAST_STEP);
        if (step_cnt_r == LAST_STEP) begin
          step_cnt_nxt = '0;
          if (status.quot_zero) begin
            state_nxt = ST_PRIME;
          end
        end else begin
          step_cnt_nxt = step_cnt_r + 1'b1;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.last_idx) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### sv/i2ra_dpath.sv
// Datapath: magnitude and radix setup, shared 8-bit-per-cycle divider,
// digit buffer and output register. Depends on i2ra_pkg and i2ra_ram.
module i2ra_dpath #(
  parameter int VALUE_WIDTH = i2ra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2ra_pkg::in_req_t     in_req,
  input  i2ra_pkg::ctl_cmd_t    cmd,
  output i2ra_pkg::dp_status_t  status,
  output logic                  out_valid,
  output i2ra_pkg::out_rsp_t    out_rsp
);
  import i2ra_pkg::*;

  localparam int STEPS  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W  = STEPS * STEP_BITS;
  localparam int ADDR_W = $clog2(VALUE_WIDTH);
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BASE_W-1:0]      radix_sel;

  logic [PAD_W-1:0]   div_r, div_nxt, div_step;
  logic [DIGIT_W-1:0] rem_r, rem_nxt, rem_step;
  logic [BASE_W-1:0]  radix_r, radix_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   ndig_r, ndig_nxt;
  logic [ADDR_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_rsp_r, out_rsp_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;

  if (VALUE_WIDTH <= IN_VALUE_W) begin : g_trunc
    assign raw = in_req.value[VALUE_WIDTH-1:0];
  end else begin : g_sext
    assign raw = {{(VALUE_WIDTH - IN_VALUE_W){in_req.value[IN_VALUE_W-1]}}, in_req.value};
  end

  // The most negative value negates to itself, which is its correct unsigned magnitude.
  assign mag = raw[VALUE_WIDTH-1] ? ((~raw) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
  assign radix_sel = ((in_req.base < MIN_RADIX) || (in_req.base > MAX_RADIX)) ?
                     DEFAULT_RADIX : in_req.base;

  // Restoring division of the top byte of the dividend by the radix.
  always_comb begin : div_c
    logic [DIGIT_W:0]     t;
    logic [DIGIT_W-1:0]   r;
    logic [STEP_BITS-1:0] q;
    r = rem_r;
    q = '0;
    t = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, div_r[PAD_W-1-i]};
      if (t >= radix_r) begin
        r = DIGIT_W'(t - radix_r);
        q[STEP_BITS-1-i] = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    rem_step = r;
    div_step = (div_r << STEP_BITS) | PAD_W'(q);
  end

  assign status.quot_zero = (div_step == '0);
  assign status.last_idx  = (rd_idx_r == '0);

  always_comb begin
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    radix_nxt  = radix_r;
    neg_nxt    = neg_r;
    ndig_nxt   = ndig_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.load) begin
      div_nxt   = PAD_W'(mag);
      rem_nxt   = '0;
      radix_nxt = radix_sel;
      neg_nxt   = raw[VALUE_WIDTH-1];
      ndig_nxt  = '0;
    end
    if (cmd.step) begin
      div_nxt = div_step;
      if (cmd.last_step) begin
        rem_nxt  = '0;
        ndig_nxt = ndig_r + 1'b1;
      end else begin
        rem_nxt = rem_step;
      end
    end
    if (cmd.prime || cmd.emit) begin
      rd_idx_nxt = ram_raddr;
    end
  end

  assign ram_we    = cmd.step & cmd.last_step;
  assign ram_raddr = cmd.prime ? ADDR_W'(ndig_r - 1'b1) : (rd_idx_r - 1'b1);

  i2ra_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ndig_r[ADDR_W-1:0]),
    .wdata (rem_step),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid_nxt         = (cmd.prime & neg_r) | cmd.emit;
  assign out_rsp_nxt.character = cmd.emit ? digit_to_ascii(ram_rdata) : ASCII_MINUS;
  assign out_rsp_nxt.last      = cmd.emit & (rd_idx_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    radix_r   <= radix_nxt;
    neg_r     <= neg_nxt;
    ndig_r    <= ndig_nxt;
    rd_idx_r  <= rd_idx_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

### sv/integer_to_radix_ascii_core.sv
// Converts a signed integer to ASCII digits in radix 2..16 (decimal for any other base),
// most significant character first, with a minus sign for negative values. A request is
// taken when start is high and busy is low. Characters then come one per cycle on out_rsp
// with out_valid high for exactly one cycle each; the receiver cannot stall them, so it
// must take every strobed character. For each digit the shared divider retires 8 dividend
// bits a cycle across the whole zero-padded dividend, W = VALUE_WIDTH bits rounded up to
// whole bytes, and the digits then stream out of a W-entry buffer.
// Depends on i2ra_pkg, i2ra_ctrl, i2ra_dpath and i2ra_ram.
module integer_to_radix_ascii_core #(
  parameter int VALUE_WIDTH = i2ra_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  i2ra_pkg::in_req_t  in_req,
  output logic               out_valid,
  output i2ra_pkg::out_rsp_t out_rsp
);
  import i2ra_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  i2ra_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  i2ra_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.last |=> !out_valid)
    else $error("character strobed right after the last one");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.character == ASCII_MINUS) ||
                  ((out_rsp.character >= ASCII_ZERO) && (out_rsp.character <= ASCII_NINE)) ||
                  ((out_rsp.character >= ASCII_UPPER_A) && (out_rsp.character <= ASCII_UPPER_F)))
    else $error("illegal output character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.character == ASCII_MINUS) |-> !out_rsp.last)
    else $error("minus sign flagged as last character");

  a_done_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid && out_rsp.last)
    else $error("request finished without a last character");
`endif

endmodule
